[src/jsu_pkg.sv]
// Shared types, character codes and decode helpers for the JSON string unescaper.
// Used by jsu_decode, jsu_out and json_string_unescaper; depends on nothing.
`default_nettype none

package jsu_pkg;

  // Depth of the hold-back store and the most bytes one input byte can release.
  localparam int unsigned HoldDepth = 11;
  localparam int unsigned MaxBytes  = 6;
  localparam int unsigned HoldCntW  = 4;
  localparam int unsigned GrpCntW   = 3;

  // Character codes.
  localparam logic [7:0] ChBsl = 8'h5C;
  localparam logic [7:0] ChU   = 8'h75;
  localparam logic [7:0] ChB   = 8'h62;
  localparam logic [7:0] ChF   = 8'h66;
  localparam logic [7:0] ChN   = 8'h6E;
  localparam logic [7:0] ChR   = 8'h72;
  localparam logic [7:0] ChT   = 8'h74;
  localparam logic [7:0] CtlBs = 8'h08;
  localparam logic [7:0] CtlFf = 8'h0C;
  localparam logic [7:0] CtlLf = 8'h0A;
  localparam logic [7:0] CtlCr = 8'h0D;
  localparam logic [7:0] CtlHt = 8'h09;

  // Surrogate ranges.
  localparam logic [15:0] HiSurLo = 16'hD800;
  localparam logic [15:0] HiSurHi = 16'hDBFF;
  localparam logic [15:0] LoSurLo = 16'hDC00;
  localparam logic [15:0] LoSurHi = 16'hDFFF;
  localparam logic [20:0] SuppBase = 21'h10000;

  // Channel payloads.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_none;
  } jsu_out_t;

  // Bytes held back while an escape is still open, oldest first.
  typedef logic [HoldDepth-1:0][7:0] jsu_held_t;

  // Up to four bytes from one small decode step, first byte at index 0.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } jsu_u8_t;

  // Group of result bytes released by one input byte.
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [GrpCntW-1:0]       cnt;
    logic                     last;
    logic                     none;
  } jsu_grp_t;

  // Next contents of the hold-back store.
  typedef struct packed {
    jsu_held_t             held;
    logic [HoldCntW-1:0]   cnt;
  } jsu_hold_t;

  // One hex digit: bit 4 flags a valid digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d = {1'b1, c[3:0] + 4'd9};
    end else begin
      d = 5'd0;
    end
    return d;
  endfunction

  // Value of the leading hex digits of four characters; s[0] comes first.
  function automatic logic [15:0] hex4(input logic [3:0][7:0] s);
    logic [15:0] v;
    logic        run;
    logic [4:0]  d;
    v   = 16'd0;
    run = 1'b1;
    for (int k = 0; k < 4; k++) begin
      d = hex_digit(s[k]);
      if (run && d[4]) begin
        v = {v[11:0], d[3:0]};
      end else begin
        run = 1'b0;
      end
    end
    return v;
  endfunction

  // Character named by a simple escape; any other letter stands for itself.
  function automatic logic [7:0] simple_esc(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ChB:     r = CtlBs;
      ChF:     r = CtlFf;
      ChN:     r = CtlLf;
      ChR:     r = CtlCr;
      ChT:     r = CtlHt;
      default: r = c;
    endcase
    return r;
  endfunction

  // UTF-8 encoding of one code point.
  function automatic jsu_u8_t utf8_enc(input logic [20:0] cp);
    jsu_u8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.n    = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.b[1] = 8'h80 | {2'b00, cp[5:0]};
      r.n    = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
      r.b[1] = 8'h80 | {2'b00, cp[11:6]};
      r.b[2] = 8'h80 | {2'b00, cp[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.b[1] = 8'h80 | {2'b00, cp[17:12]};
      r.b[2] = 8'h80 | {2'b00, cp[11:6]};
      r.b[3] = 8'h80 | {2'b00, cp[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

  // Decode a short run of at most three characters, such as the tail of a string.
  // A backslash-u here can never be complete, so it is dropped.
  function automatic jsu_u8_t short_decode(input logic [2:0][7:0] t, input logic [1:0] len);
    jsu_u8_t    r;
    logic [1:0] pos;
    logic [1:0] nx;
    r   = '0;
    pos = 2'd0;
    nx  = 2'd0;
    for (int s = 0; s < 3; s++) begin
      if (pos < len) begin
        nx = pos + 2'd1;
        if (t[pos] != ChBsl) begin
          r.b[r.n[1:0]] = t[pos];
          r.n           = r.n + 3'd1;
          pos           = nx;
        end else if (nx >= len) begin
          r.b[r.n[1:0]] = ChBsl;
          r.n           = r.n + 3'd1;
          pos           = nx;
        end else if (t[nx] != ChU) begin
          r.b[r.n[1:0]] = simple_esc(t[nx]);
          r.n           = r.n + 3'd1;
          pos           = pos + 2'd2;
        end else begin
          pos = pos + 2'd2;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/jsu_decode.sv]
// Combinational decode of one input byte against the held-back escape bytes.
// Depends on jsu_pkg for types, character codes and the encode helpers.
`default_nettype none

module jsu_decode (
  input  wire jsu_pkg::jsu_held_t           held,
  input  wire logic [jsu_pkg::HoldCntW-1:0] hold_cnt,
  input  wire jsu_pkg::jsu_in_t             item,
  output jsu_pkg::jsu_grp_t                 grp,
  output logic                              emit,
  output jsu_pkg::jsu_hold_t                hold_nxt
);
  import jsu_pkg::*;

  logic [HoldDepth:0][7:0] w;
  logic [7:0]              c;
  logic                    fin;
  logic [15:0]             cp1;
  logic [15:0]             lo;
  logic                    hi1;
  logic                    lo_low;
  logic                    lo_high;
  logic                    mism;
  logic                    keep;
  logic                    shift6;
  jsu_u8_t                 seg1;
  jsu_u8_t                 seg2;
  logic [GrpCntW-1:0]      j;
  logic [GrpCntW-1:0]      total;

  assign c   = item.in_byte;
  assign fin = item.in_last;

  // Window of held bytes with the new byte placed right after them.
  always_comb begin
    for (int i = 0; i < HoldDepth; i++) begin
      w[i] = (HoldCntW'(i) == hold_cnt) ? c : held[i];
    end
    w[HoldDepth] = c;
  end

  // Both escape values that a surrogate pair may need.
  assign cp1     = hex4({w[5], w[4], w[3], w[2]});
  assign lo      = hex4({w[11], w[10], w[9], w[8]});
  assign hi1     = (cp1 >= HiSurLo) && (cp1 <= HiSurHi);
  assign lo_low  = (lo >= LoSurLo) && (lo <= LoSurHi);
  assign lo_high = (lo >= HiSurLo) && (lo <= HiSurHi);
  assign mism    = ((hold_cnt == 4'd6) && (c != ChBsl)) || ((hold_cnt == 4'd7) && (c != ChU));

  // The held count tells which part of an escape is open; decide per case.
  always_comb begin
    seg1   = '0;
    seg2   = '0;
    keep   = 1'b0;
    shift6 = 1'b0;
    case (hold_cnt) inside
      4'd0, 4'd1: begin
        if (!fin && (((hold_cnt == 4'd0) && (c == ChBsl)) ||
                     ((hold_cnt == 4'd1) && (c == ChU)))) begin
          keep = 1'b1;
        end else begin
          seg2 = short_decode({8'h00, w[1], w[0]}, {1'b0, hold_cnt[0]} + 2'd1);
        end
      end
      [4'd2:4'd4]: begin
        if (!fin) begin
          keep = 1'b1;
        end else begin
          seg2 = short_decode({w[4], w[3], w[2]}, 2'(hold_cnt - 4'd1));
        end
      end
      4'd5: begin
        if (hi1 && !fin) begin
          keep = 1'b1;
        end else begin
          seg1 = utf8_enc({5'd0, cp1});
        end
      end
      [4'd6:4'd10]: begin
        if (!mism && !fin) begin
          keep = 1'b1;
        end else begin
          // The high surrogate stands alone; what follows it is decoded as text.
          seg1 = utf8_enc({5'd0, cp1});
          if (hold_cnt >= 4'd8) begin
            seg2 = short_decode({w[10], w[9], w[8]}, 2'(hold_cnt - 4'd7));
          end else begin
            seg2 = short_decode({8'h00, w[7], w[6]}, 2'(hold_cnt - 4'd5));
          end
        end
      end
      4'd11: begin
        if (lo_low) begin
          seg1 = utf8_enc(SuppBase + {1'b0, cp1[9:0], lo[9:0]});
        end else begin
          seg1 = utf8_enc({5'd0, cp1});
          if (lo_high && !fin) begin
            shift6 = 1'b1;
          end else begin
            seg2 = utf8_enc({5'd0, lo});
          end
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Join the two byte segments into one result group.
  always_comb begin
    grp   = '0;
    j     = '0;
    total = seg1.n + seg2.n;
    for (int i = 0; i < MaxBytes; i++) begin
      j = GrpCntW'(i) - seg1.n;
      if (GrpCntW'(i) < seg1.n) begin
        grp.bytes[i] = seg1.b[2'(i)];
      end else if (j < seg2.n) begin
        grp.bytes[i] = seg2.b[j[1:0]];
      end else begin
        grp.bytes[i] = 8'h00;
      end
    end
    grp.last = fin;
    if (fin && (total == '0)) begin
      grp.cnt  = GrpCntW'(1);
      grp.none = 1'b1;
    end else begin
      grp.cnt  = total;
      grp.none = 1'b0;
    end
    emit = (total != '0) || fin;
  end

  // Next contents of the hold-back store.
  always_comb begin
    hold_nxt.held = held;
    hold_nxt.cnt  = '0;
    if (keep) begin
      for (int i = 0; i < HoldDepth; i++) begin
        if (HoldCntW'(i) == hold_cnt) begin
          hold_nxt.held[i] = c;
        end
      end
      hold_nxt.cnt = hold_cnt + 4'd1;
    end else if (shift6) begin
      for (int i = 0; i < 6; i++) begin
        hold_nxt.held[i] = w[i + 6];
      end
      hold_nxt.cnt = 4'd6;
    end
  end

endmodule

`default_nettype wire

[src/jsu_out.sv]
// Result register that shifts a group of decoded bytes out one transfer per cycle while out_stall is low.
// Depends on jsu_pkg for the group and output payload types.
`default_nettype none

module jsu_out (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire jsu_pkg::jsu_grp_t grp,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jsu_pkg::jsu_out_t      out_data
);
  import jsu_pkg::*;

  logic [MaxBytes-1:0][7:0] bytes_r;
  logic [MaxBytes-1:0][7:0] bytes_nxt;
  logic [GrpCntW-1:0]       cnt_r;
  logic [GrpCntW-1:0]       cnt_nxt;
  logic                     last_r;
  logic                     last_nxt;
  logic                     none_r;
  logic                     none_nxt;
  logic                     take;

  assign out_valid = (cnt_r != '0);
  assign take      = out_valid && !out_stall;
  assign free      = (cnt_r == '0) || (take && (cnt_r == GrpCntW'(1)));

  // Front byte, with the end flag only on the last byte of the group.
  assign out_data = {bytes_r[0], last_r && (cnt_r == GrpCntW'(1)), none_r};

  // Load a new group, or shift the sent byte out of the front.
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    last_nxt  = last_r;
    none_nxt  = none_r;
    if (load) begin
      bytes_nxt = grp.bytes;
      cnt_nxt   = grp.cnt;
      last_nxt  = grp.last;
      none_nxt  = grp.none;
    end else if (take) begin
      bytes_nxt = {8'h00, bytes_r[MaxBytes-1:1]};
      cnt_nxt   = cnt_r - GrpCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    last_r  <= last_nxt;
    none_r  <= none_nxt;
  end

endmodule

`default_nettype wire

[src/json_string_unescaper.sv]
// Top level of the JSON string unescaper: input register, hold-back store,
// decoder and result register. Depends on jsu_pkg, jsu_decode and jsu_out.
//
// Usage: bytes of a JSON string body (quotes removed) enter on in_data with
// in_last set on the final byte. Decoded UTF-8 bytes leave on out_data, one
// per transfer; out_last marks the final byte of the string, and out_none
// marks an end-only transfer when the final input byte released no byte.
// An accepted byte is held in the input register and decoded from there;
// its results pass through the result register before they leave.
// Throughput: one input byte per cycle while each byte releases at most one
// result and out_stall is low. A byte that releases k bytes (up to six, for
// a completed escape) keeps the result register busy until all k leave on
// the single output byte lane; in_stall rises while the decoded item cannot
// move on. Bytes that only extend an open escape need not wait on the output.
// Reset empties the input and result registers and the hold-back count.
// When out_stall is high the current result holds; a decoded item with
// results waits in the input register, and in_stall is high while it waits.
`default_nettype none

module json_string_unescaper (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire jsu_pkg::jsu_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output jsu_pkg::jsu_out_t      out_data
);
  import jsu_pkg::*;

  logic                in_vld_r;
  logic                in_vld_nxt;
  jsu_in_t             item_r;
  jsu_held_t           held_r;
  logic [HoldCntW-1:0] hold_cnt_r;
  jsu_grp_t            grp;
  logic                emit;
  jsu_hold_t           hold_nxt;
  logic                free;
  logic                move;
  logic                accept;

  // The registered item moves on when it has no result or the result register frees.
  assign move     = in_vld_r && (!emit || free);
  assign in_stall = in_vld_r && !move;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (move) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      hold_cnt_r <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (move) begin
        hold_cnt_r <= hold_nxt.cnt;
      end
    end
  end

  // Input payload and held escape bytes.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (move) begin
      held_r <= hold_nxt.held;
    end
  end

  jsu_decode u_decode (
    .held     (held_r),
    .hold_cnt (hold_cnt_r),
    .item     (item_r),
    .grp      (grp),
    .emit     (emit),
    .hold_nxt (hold_nxt)
  );

  jsu_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (move && emit),
    .grp       (grp),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
